// ===== rtl/srcd_pkg.sv =====
// shared types, constants and codes for the signed rank count distribution block
// no dependencies; imported by srcd_ctrl, srcd_datapath and the top level
`default_nettype none

package srcd_pkg;

    localparam int MAX_RANKS_DEF = 32;

    localparam int N_W    = 6;
    localparam int SUM_W  = 10;
    localparam int CNT_W  = 33;
    localparam int ENT_W  = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [1:0] ACT_POINT = 2'd0;
    localparam logic [1:0] ACT_CUM   = 2'd1;
    localparam logic [1:0] ACT_QUANT = 2'd2;

    localparam logic REG_SAMPLE_SIZE = 1'b0;

    localparam logic [N_W-1:0] SAMPLE_SIZE_RST = 6'd1;

    typedef struct packed {
        logic [1:0]       action;
        logic [SUM_W-1:0] rank_sum;
        logic [CNT_W-1:0] target_count;
        logic             upper_tail;
    } query_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] quantile_sum;
        logic             out_of_range;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_PASS,
        ST_BUILD_RD,
        ST_BUILD_WR,
        ST_SETUP,
        ST_POINT,
        ST_WALK,
        ST_RESULT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic clear_init;
        logic clear_step;
        logic pass_init;
        logic pass_start;
        logic pass_next;
        logic build_rd;
        logic build_wr;
        logic build_done;
        logic setup;
        logic walk_step;
        logic point_result;
        logic walk_result;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic       need_rebuild;
        logic       clear_last;
        logic       pass_over;
        logic       build_last;
        logic       direct;
        logic       walk_done;
        logic [1:0] act;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/signed_rank_count_distribution_top.sv =====
// top level: sample size register on the config port, controller and datapath
// depends on srcd_pkg, srcd_ctrl and srcd_datapath
`default_nettype none

// Exact signed-rank (Wilcoxon) subset counts for n = 1..MAX_RANKS ranks; a
// probability is count / 2^n. One query word is taken at a time and one result
// word is returned per query; the result register lets the next query start while
// a result waits. Each query goes through the single-write-port count table: a
// point count reads one entry; a cumulative count walks the sums up to rank_sum
// (no walk when rank_sum reaches the top sum); a quantile walks up to q, where q
// is the returned rank sum (no walk for the edge and saturated cases); the unused
// action code needs no walk. After a change of sample_size the next query first
// rebuilds the table: it clears entries 0..half, then for each pass j = 1..min(n,
// half) it updates each entry from half down to j, where half = n(n+1)/4 rounded
// down.

module signed_rank_count_distribution_top
    import srcd_pkg::*;
#(
    parameter int MAX_RANKS = MAX_RANKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              query_valid,
    output logic              query_ready,
    input  query_t            query,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    logic [N_W-1:0] sample_size_reg;
    logic           cfg_wr;
    logic           sel_size;
    logic           invalidate;
    dp_cmd_t        cmd;
    dp_status_t     status;

    assign pready     = 1'b1;
    assign sel_size   = (paddr[ADDR_W-1] == REG_SAMPLE_SIZE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign invalidate = cfg_wr && sel_size && (pwdata[N_W-1:0] != sample_size_reg);
    assign prdata     = sel_size ? DATA_W'(sample_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_size_reg <= SAMPLE_SIZE_RST;
        end
        else if (cfg_wr && sel_size)
        begin
            sample_size_reg <= pwdata[N_W-1:0];
        end
    end

    srcd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    srcd_datapath #(
        .MAX_RANKS (MAX_RANKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_size (sample_size_reg),
        .invalidate  (invalidate),
        .query       (query),
        .cmd         (cmd),
        .status      (status),
        .result      (result)
    );

endmodule

`default_nettype wire

// ===== rtl/srcd_datapath.sv =====
// datapath: count table memory, subset-sum rebuild, table walk and result registers
// depends on srcd_pkg
`default_nettype none

module srcd_datapath
    import srcd_pkg::*;
#(
    parameter int MAX_RANKS = MAX_RANKS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [N_W-1:0]   sample_size,
    input  logic             invalidate,
    input  query_t           query,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output result_t          result
);

    localparam int HALF_DEPTH = MAX_RANKS * (MAX_RANKS + 1) / 4 + 1;
    localparam int AW         = $clog2(HALF_DEPTH);

    logic [N_W-1:0]   eff_n;
    logic [12:0]      prod;

    query_t           item_reg;
    logic [N_W-1:0]   n_reg;
    logic [SUM_W-1:0] top_reg;
    logic [SUM_W-2:0] half_reg;
    logic [CNT_W-1:0] total_reg;
    logic [SUM_W-1:0] half_ext;

    logic             table_valid_reg;
    logic [N_W-1:0]   table_n_reg;

    logic [SUM_W-1:0] idx_reg;
    logic [SUM_W-1:0] idx_diff;
    logic [N_W-1:0]   j_reg;

    logic [ENT_W-1:0] mem [HALF_DEPTH];
    logic [ENT_W-1:0] rd_a_reg;
    logic [ENT_W-1:0] rd_b_reg;
    logic [AW-1:0]    addr_a;
    logic [AW-1:0]    addr_b;
    logic [AW-1:0]    waddr;
    logic [ENT_W-1:0] wdata;
    logic             we;

    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] acc_next;
    logic [CNT_W-1:0] goal;
    logic [CNT_W-1:0] goal_reg;
    logic             pend_reg;
    logic [SUM_W-1:0] pend_idx_reg;
    logic [SUM_W-1:0] qs_reg;
    logic             is_quant;
    logic             is_cum;
    logic             hit;
    logic             direct;

    result_t          res_direct;
    result_t          res_point;
    result_t          res_walk;
    result_t          res_reg;
    result_t          out_reg;

    // fold a rank sum onto the stored half of the table
    function automatic logic [AW-1:0] mirror_addr(
        input logic [SUM_W-1:0] k,
        input logic [SUM_W-1:0] top,
        input logic [SUM_W-1:0] half
    );
        logic [SUM_W-1:0] m;
        if (k > top)
        begin
            m = '0;
        end
        else if (k > half)
        begin
            m = top - k;
        end
        else
        begin
            m = k;
        end
        return m[AW-1:0];
    endfunction

    always_comb
    begin
        if (sample_size == '0)
        begin
            eff_n = N_W'(1);
        end
        else if (sample_size > N_W'(MAX_RANKS))
        begin
            eff_n = N_W'(MAX_RANKS);
        end
        else
        begin
            eff_n = sample_size;
        end
    end

    assign prod     = 13'(eff_n) * (13'(eff_n) + 13'd1);
    assign half_ext = {1'b0, half_reg};
    assign idx_diff = idx_reg - SUM_W'(j_reg);

    // memory ports
    assign addr_a = cmd.build_rd ? idx_reg[AW-1:0]
                  : mirror_addr(cmd.walk_step ? idx_reg : item_reg.rank_sum, top_reg, half_ext);
    assign addr_b = idx_diff[AW-1:0];
    assign we     = cmd.clear_step || cmd.build_wr;
    assign waddr  = idx_reg[AW-1:0];
    assign wdata  = cmd.clear_step ? ((idx_reg == '0) ? ENT_W'(1) : '0)
                                   : rd_a_reg + rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // walk arithmetic
    assign is_quant = (item_reg.action == ACT_QUANT);
    assign is_cum   = (item_reg.action == ACT_CUM);
    assign goal     = item_reg.upper_tail ? total_reg - item_reg.target_count
                                          : item_reg.target_count;
    assign acc_next = acc_reg + CNT_W'(rd_a_reg);
    assign hit      = (acc_next >= goal_reg);

    // results that need no walk
    always_comb
    begin
        res_direct = '0;
        direct     = 1'b0;
        unique case (item_reg.action)
            ACT_POINT:
            begin
                direct = 1'b0;
            end
            ACT_CUM:
            begin
                if (item_reg.rank_sum >= top_reg)
                begin
                    direct           = 1'b1;
                    res_direct.count = item_reg.upper_tail ? '0 : total_reg;
                end
            end
            ACT_QUANT:
            begin
                if (item_reg.target_count > total_reg)
                begin
                    direct                  = 1'b1;
                    res_direct.quantile_sum = top_reg;
                    res_direct.out_of_range = 1'b1;
                end
                else if (goal == '0)
                begin
                    direct = 1'b1;
                end
                else if (goal == total_reg)
                begin
                    direct                  = 1'b1;
                    res_direct.quantile_sum = top_reg;
                end
            end
            default:
            begin
                direct = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        res_point       = '0;
        res_point.count = (item_reg.rank_sum > top_reg) ? '0 : CNT_W'(rd_a_reg);
    end

    always_comb
    begin
        res_walk              = '0;
        res_walk.count        = is_cum ? (item_reg.upper_tail ? total_reg - acc_reg : acc_reg)
                                       : '0;
        res_walk.quantile_sum = is_quant ? qs_reg : '0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_valid_reg <= 1'b0;
            table_n_reg     <= '0;
            pend_reg        <= 1'b0;
        end
        else
        begin
            if (invalidate)
            begin
                table_valid_reg <= 1'b0;
            end
            else if (cmd.build_done)
            begin
                table_valid_reg <= 1'b1;
                table_n_reg     <= n_reg;
            end
            if (cmd.setup)
            begin
                pend_reg <= 1'b0;
            end
            else if (cmd.walk_step)
            begin
                pend_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg  <= query;
            n_reg     <= eff_n;
            top_reg   <= prod[SUM_W:1];
            half_reg  <= prod[SUM_W:2];
            total_reg <= CNT_W'(1) << eff_n;
        end
        if (cmd.clear_init)
        begin
            idx_reg <= '0;
        end
        if (cmd.clear_step)
        begin
            idx_reg <= idx_reg + SUM_W'(1);
        end
        if (cmd.pass_init)
        begin
            j_reg <= N_W'(1);
        end
        if (cmd.pass_start)
        begin
            idx_reg <= half_ext;
        end
        if (cmd.pass_next)
        begin
            j_reg <= j_reg + N_W'(1);
        end
        if (cmd.build_wr)
        begin
            idx_reg <= idx_reg - SUM_W'(1);
        end
        if (cmd.setup)
        begin
            acc_reg  <= '0;
            idx_reg  <= '0;
            goal_reg <= goal;
            if (direct)
            begin
                res_reg <= res_direct;
            end
        end
        if (cmd.walk_step)
        begin
            idx_reg      <= idx_reg + SUM_W'(1);
            pend_idx_reg <= idx_reg;
            if (pend_reg)
            begin
                acc_reg <= acc_next;
                qs_reg  <= pend_idx_reg;
            end
        end
        if (cmd.point_result)
        begin
            res_reg <= res_point;
        end
        if (cmd.walk_result)
        begin
            res_reg <= res_walk;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    always_comb
    begin
        status              = '0;
        status.need_rebuild = !table_valid_reg || (table_n_reg != n_reg);
        status.clear_last   = (idx_reg == half_ext);
        status.pass_over    = (j_reg > n_reg) || (SUM_W'(j_reg) > half_ext);
        status.build_last   = (idx_reg == SUM_W'(j_reg));
        status.direct       = direct;
        status.walk_done    = pend_reg && (is_quant ? (hit || pend_idx_reg == top_reg)
                                                    : (pend_idx_reg == item_reg.rank_sum));
        status.act          = item_reg.action;
    end

    assign result = out_reg;

    a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> idx_reg <= half_ext)
        else $error("clear sweep beyond half table");

    a_build_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.build_wr |-> (idx_reg <= half_ext && idx_reg >= SUM_W'(j_reg)))
        else $error("rebuild update outside its pass range");

    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk_step && pend_reg) |-> acc_next <= total_reg)
        else $error("running count exceeds total");

endmodule

`default_nettype wire

// ===== rtl/srcd_ctrl.sv =====
// controller state machine: sequences rebuild, query walk and result handoff
// depends on srcd_pkg; drives srcd_datapath through command and status words
`default_nettype none

module srcd_ctrl
    import srcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       query_valid,
    output logic       query_ready,
    output logic       result_valid,
    input  logic       result_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.need_rebuild)
                begin
                    cmd.clear_init = 1'b1;
                    state_next     = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    cmd.pass_init = 1'b1;
                    state_next    = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (status.pass_over)
                begin
                    cmd.build_done = 1'b1;
                    state_next     = ST_SETUP;
                end
                else
                begin
                    cmd.pass_start = 1'b1;
                    state_next     = ST_BUILD_RD;
                end
            end
            ST_BUILD_RD:
            begin
                cmd.build_rd = 1'b1;
                state_next   = ST_BUILD_WR;
            end
            ST_BUILD_WR:
            begin
                cmd.build_wr = 1'b1;
                if (status.build_last)
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = ST_PASS;
                end
                else
                begin
                    state_next = ST_BUILD_RD;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                if (status.direct)
                begin
                    state_next = ST_DONE;
                end
                else if (status.act == ACT_POINT)
                begin
                    state_next = ST_POINT;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_POINT:
            begin
                cmd.point_result = 1'b1;
                state_next       = ST_DONE;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                cmd.walk_result = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign query_ready  = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    a_table_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETUP |-> !status.need_rebuild)
        else $error("query started on a stale count table");

    a_walk_action: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> (status.act == ACT_CUM || status.act == ACT_QUANT))
        else $error("table walk for an action that needs none");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result word raised outside the done state");

endmodule

`default_nettype wire
